@@ hw/rtl/fwt_pkg.sv @@
// shared types and constants for the futex waiter table
package fwt_pkg;

  localparam int WaiterSlotsDef = 64;
  localparam int TaskIdBitsDef  = 8;

  localparam int AddrW     = 32;
  localparam int WordW     = 32;
  localparam int TaskInW   = 8;
  localparam int OpW       = 8;
  localparam int CountOutW = 7;

  localparam int InTdataW  = 104;
  localparam int InTuserW  = 8;
  localparam int OutTdataW = 16;
  localparam int OutTuserW = 3;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // op code with the private flag stripped
  localparam logic [OpW-2:0] OpWait = 7'd0;
  localparam logic [OpW-2:0] OpWake = 7'd1;

  localparam logic [1:0] StOk          = 2'd0;
  localparam logic [1:0] StChanged     = 2'd1;
  localparam logic [1:0] StFull        = 2'd2;
  localparam logic [1:0] StUnsupported = 2'd3;

  typedef enum logic [1:0] {
    K_WAIT,
    K_CHANGED,
    K_WAKE,
    K_UNSUP
  } kind_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_FIND,
    ENG_SCAN,
    ENG_CMP,
    ENG_DONE
  } eng_state_t;

  typedef struct packed {
    kind_t               kind;
    logic [AddrW-1:0]    addr;
    logic [WordW-1:0]    arg;
    logic [TaskInW-1:0]  task_id;
  } qitem_t;

endpackage

@@ hw/rtl/fwt_front.sv @@
// front end: accepts items, classifies the op code and queues the work
module fwt_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [fwt_pkg::InTdataW-1:0]  in_tdata,
  input  logic [fwt_pkg::InTuserW-1:0]  in_tuser,
  output logic                          q_valid,
  output fwt_pkg::qitem_t               q_item,
  input  logic                          q_pop
);

  fwt_pkg::qitem_t               fifo_r [fwt_pkg::QDepth];
  logic [fwt_pkg::QPtrW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [fwt_pkg::QPtrW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [fwt_pkg::QCntW-1:0]     cnt_r, cnt_nxt;
  logic                          push;
  fwt_pkg::qitem_t               item;
  logic [fwt_pkg::OpW-2:0]       op;
  logic [fwt_pkg::WordW-1:0]     cur_val;

  assign in_tready = cnt_r != fwt_pkg::QCntW'(fwt_pkg::QDepth);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = cnt_r != '0;
  assign q_item    = fifo_r[rd_ptr_r];

  // private flag dropped, value check done here so the back end sees a kind
  always_comb begin
    op           = in_tuser[fwt_pkg::OpW-2:0];
    cur_val      = in_tdata[63:32];
    item.addr    = in_tdata[31:0];
    item.arg     = in_tdata[95:64];
    item.task_id = in_tdata[103:96];
    case (op)
      fwt_pkg::OpWait: begin
        item.kind = (cur_val == item.arg) ? fwt_pkg::K_WAIT : fwt_pkg::K_CHANGED;
      end
      fwt_pkg::OpWake: begin
        item.kind = fwt_pkg::K_WAKE;
      end
      default: begin
        item.kind = fwt_pkg::K_UNSUP;
      end
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push  ? fwt_pkg::QPtrW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? fwt_pkg::QPtrW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = fwt_pkg::QCntW'(cnt_r + 1'b1);
    end else if (!push && q_pop) begin
      cnt_nxt = fwt_pkg::QCntW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= item;
    end
  end

endmodule

@@ hw/rtl/fwt_engine.sv @@
// back end: slot table, free-slot and match scans, result register
module fwt_engine #(
  parameter int WAITER_SLOTS = fwt_pkg::WaiterSlotsDef,
  parameter int TASK_ID_BITS = fwt_pkg::TaskIdBitsDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  fwt_pkg::qitem_t                q_item,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [fwt_pkg::OutTdataW-1:0]  out_tdata,
  output logic [fwt_pkg::OutTuserW-1:0]  out_tuser,
  output logic                           out_tlast
);

  localparam int IdxW = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
  localparam int CntW = $clog2(WAITER_SLOTS + 1);
  localparam int MemW = fwt_pkg::AddrW + TASK_ID_BITS;

  fwt_pkg::eng_state_t state_r, state_nxt;

  logic [CntW-1:0]         idx_r, idx_nxt;
  logic [CntW-1:0]         woken_r, woken_nxt;
  logic                    pend_r, pend_nxt;
  logic [TASK_ID_BITS-1:0] pend_task_r, pend_task_nxt;
  logic [WAITER_SLOTS-1:0] valid_r;
  logic [MemW-1:0]         mem [WAITER_SLOTS];
  logic [MemW-1:0]         rd_data_r;

  logic                              out_valid_r;
  logic [1:0]                        out_status_r;
  logic [fwt_pkg::TaskInW-1:0]       out_task_r;
  logic                              out_tv_r;
  logic [fwt_pkg::CountOutW-1:0]     out_count_r;
  logic                              out_last_r;

  logic                              emit, e_tv, e_last;
  logic [1:0]                        e_status;
  logic [fwt_pkg::TaskInW-1:0]       e_task;
  logic [fwt_pkg::CountOutW-1:0]     e_count;
  logic                              set_slot, clr_slot;

  logic [IdxW-1:0]         idx;
  logic                    at_end, cur_valid, quota_hit, rd_hit, can_emit;
  logic [TASK_ID_BITS-1:0] task_st;

  assign idx       = idx_r[IdxW-1:0];
  assign at_end    = idx_r == CntW'(WAITER_SLOTS);
  assign cur_valid = valid_r[idx];
  assign quota_hit = 32'(woken_r) >= q_item.arg;
  assign rd_hit    = rd_data_r[fwt_pkg::AddrW-1:0] == q_item.addr;
  assign can_emit  = !out_valid_r || out_tready;
  assign task_st   = TASK_ID_BITS'(q_item.task_id);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fwt_pkg::ENG_IDLE: begin
        if (q_valid && q_item.kind == fwt_pkg::K_WAIT) begin
          state_nxt = fwt_pkg::ENG_FIND;
        end else if (q_valid && q_item.kind == fwt_pkg::K_WAKE) begin
          state_nxt = fwt_pkg::ENG_SCAN;
        end
      end
      fwt_pkg::ENG_FIND: begin
        if ((at_end || !cur_valid) && can_emit) begin
          state_nxt = fwt_pkg::ENG_IDLE;
        end
      end
      fwt_pkg::ENG_SCAN: begin
        if (at_end || quota_hit) begin
          state_nxt = fwt_pkg::ENG_DONE;
        end else if (cur_valid) begin
          state_nxt = fwt_pkg::ENG_CMP;
        end
      end
      fwt_pkg::ENG_CMP: begin
        if (!(rd_hit && pend_r && !can_emit)) begin
          state_nxt = fwt_pkg::ENG_SCAN;
        end
      end
      fwt_pkg::ENG_DONE: begin
        if (can_emit) begin
          state_nxt = fwt_pkg::ENG_IDLE;
        end
      end
      default: begin
        state_nxt = fwt_pkg::ENG_IDLE;
      end
    endcase
  end

  // datapath control and result selection
  always_comb begin
    emit          = 1'b0;
    e_status      = fwt_pkg::StOk;
    e_task        = '0;
    e_tv          = 1'b0;
    e_count       = '0;
    e_last        = 1'b1;
    q_pop         = 1'b0;
    set_slot      = 1'b0;
    clr_slot      = 1'b0;
    idx_nxt       = idx_r;
    woken_nxt     = woken_r;
    pend_nxt      = pend_r;
    pend_task_nxt = pend_task_r;
    case (state_r)
      fwt_pkg::ENG_IDLE: begin
        idx_nxt   = '0;
        woken_nxt = '0;
        pend_nxt  = 1'b0;
        if (q_valid && can_emit && q_item.kind == fwt_pkg::K_CHANGED) begin
          emit     = 1'b1;
          e_status = fwt_pkg::StChanged;
          q_pop    = 1'b1;
        end else if (q_valid && can_emit && q_item.kind == fwt_pkg::K_UNSUP) begin
          emit     = 1'b1;
          e_status = fwt_pkg::StUnsupported;
          q_pop    = 1'b1;
        end
      end
      fwt_pkg::ENG_FIND: begin
        if (at_end) begin
          if (can_emit) begin
            emit     = 1'b1;
            e_status = fwt_pkg::StFull;
            q_pop    = 1'b1;
          end
        end else if (!cur_valid) begin
          if (can_emit) begin
            emit     = 1'b1;
            q_pop    = 1'b1;
            set_slot = 1'b1;
          end
        end else begin
          idx_nxt = CntW'(idx_r + 1'b1);
        end
      end
      fwt_pkg::ENG_SCAN: begin
        if (!(at_end || quota_hit) && !cur_valid) begin
          idx_nxt = CntW'(idx_r + 1'b1);
        end
      end
      fwt_pkg::ENG_CMP: begin
        if (rd_hit) begin
          // a new match releases the one held back, which is then not the last
          if (!pend_r || can_emit) begin
            emit          = pend_r;
            e_task        = fwt_pkg::TaskInW'(pend_task_r);
            e_tv          = 1'b1;
            e_count       = fwt_pkg::CountOutW'(woken_r);
            e_last        = 1'b0;
            pend_nxt      = 1'b1;
            pend_task_nxt = rd_data_r[MemW-1:fwt_pkg::AddrW];
            woken_nxt     = CntW'(woken_r + 1'b1);
            clr_slot      = 1'b1;
            idx_nxt       = CntW'(idx_r + 1'b1);
          end
        end else begin
          idx_nxt = CntW'(idx_r + 1'b1);
        end
      end
      fwt_pkg::ENG_DONE: begin
        if (can_emit) begin
          emit  = 1'b1;
          q_pop = 1'b1;
          if (pend_r) begin
            e_task  = fwt_pkg::TaskInW'(pend_task_r);
            e_tv    = 1'b1;
            e_count = fwt_pkg::CountOutW'(woken_r);
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fwt_pkg::ENG_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      woken_r     <= '0;
      pend_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      woken_r <= woken_nxt;
      pend_r  <= pend_nxt;
      if (set_slot) begin
        valid_r[idx] <= 1'b1;
      end else if (clr_slot) begin
        valid_r[idx] <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_task_r <= pend_task_nxt;
    if (emit) begin
      out_status_r <= e_status;
      out_task_r   <= e_task;
      out_tv_r     <= e_tv;
      out_count_r  <= e_count;
      out_last_r   <= e_last;
    end
  end

  // slot store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (set_slot) begin
      mem[idx] <= {task_st, q_item.addr};
    end
    rd_data_r <= mem[idx];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_count_r, out_task_r};
  assign out_tuser  = {out_tv_r, out_status_r};
  assign out_tlast  = out_last_r;

endmodule

@@ hw/rtl/futex_waiter_table.sv @@
// top level of the futex waiter table: front end, queue and slot engine
// an accepted item is registered in the queue before the engine sees it; the first result
//   is registered in the cycle after the engine decides it
// unsupported ops and failed value checks are answered straight from idle; a wait scans
//   up to the lowest free slot; a wake takes a step per slot scanned and a compare step per
//   occupied one, plus dispatch and close; the serial slot scan and receiver stalls limit the rate
// reset: rst_n low clears every slot valid bit, the queue and the result register
module futex_waiter_table #(
  parameter int WAITER_SLOTS = fwt_pkg::WaiterSlotsDef,
  parameter int TASK_ID_BITS = fwt_pkg::TaskIdBitsDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // address [31:0], current_value [63:32], expected_or_count [95:64], task_id [103:96]
  input  logic [fwt_pkg::InTdataW-1:0]   in_tdata,
  // operation [7:0]
  input  logic [fwt_pkg::InTuserW-1:0]   in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // woken_task [7:0], woken_count [14:8], zero pad [15]
  output logic [fwt_pkg::OutTdataW-1:0]  out_tdata,
  // status [1:0], task_valid [2]
  output logic [fwt_pkg::OutTuserW-1:0]  out_tuser,
  output logic                           out_tlast
);

  // queued work between the two halves
  logic            q_valid;
  logic            q_pop;
  fwt_pkg::qitem_t q_item;

  // front end classifies wait/wake/unsupported and does the value check
  fwt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  // engine walks the slots one at a time and drives the result register
  fwt_engine #(
    .WAITER_SLOTS (WAITER_SLOTS),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
